@@ hw/rtl/aabbrst_pkg.sv @@
// Package for the transformed bounding-box block: widths, payload types,
// register codes and the sine coefficient table. No dependencies.
`default_nettype none

package aabbrst_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COORD_BITS = 32;
	localparam int ANGLE_BITS = 16;

	// Rotated coordinates grow by at most sqrt(3), so two guard bits suffice.
	localparam int ROT_BITS   = COORD_BITS + 2;
	localparam int Q_BITS     = 30;
	localparam int TRIG_BITS  = 32;
	localparam int CORNERS    = 8;
	localparam int CORNER_BITS = $clog2(CORNERS);
	localparam int CFG_ADDR_BITS = 3;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_LOW_X  = 3'd0,
		REG_LOW_Y  = 3'd1,
		REG_LOW_Z  = 3'd2,
		REG_HIGH_X = 3'd3,
		REG_HIGH_Y = 3'd4,
		REG_HIGH_Z = 3'd5
	} cfg_reg_t;

	// Odd polynomial for sin(u*pi/2), Q30, lowest order first.
	localparam logic [TRIG_BITS-1:0] SIN_COEF [7] = '{
		32'd1686629713, 32'd693598669, 32'd85569306, 32'd5026995,
		32'd172272, 32'd3864, 32'd74
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] shift_x;
		logic signed [COORD_BITS-1:0] shift_y;
		logic signed [COORD_BITS-1:0] shift_z;
		logic signed [COORD_BITS-1:0] gain_x;
		logic signed [COORD_BITS-1:0] gain_y;
		logic signed [COORD_BITS-1:0] gain_z;
		logic signed [ANGLE_BITS-1:0] turn_x;
		logic signed [ANGLE_BITS-1:0] turn_y;
		logic signed [ANGLE_BITS-1:0] turn_z;
	} item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] box_low_x;
		logic signed [COORD_BITS-1:0] box_low_y;
		logic signed [COORD_BITS-1:0] box_low_z;
		logic signed [COORD_BITS-1:0] box_high_x;
		logic signed [COORD_BITS-1:0] box_high_y;
		logic signed [COORD_BITS-1:0] box_high_z;
		logic                         clipped;
	} res_t;

	// One classified transaction: sines and cosines per axis plus scale and shift.
	typedef struct packed {
		logic [2:0][TRIG_BITS-1:0]  sn;
		logic [2:0][TRIG_BITS-1:0]  cs;
		logic [2:0][COORD_BITS-1:0] gain;
		logic [2:0][COORD_BITS-1:0] shift;
	} job_t;

	typedef struct packed {
		logic [2:0][COORD_BITS-1:0] lo;
		logic [2:0][COORD_BITS-1:0] hi;
	} box_t;

endpackage

`default_nettype wire

@@ hw/rtl/aabbrst_sine.sv @@
// One sine lane: Horner evaluation of the sine polynomial, one product per cycle.
// Depends on aabbrst_pkg.
`default_nettype none

module aabbrst_sine
	import aabbrst_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic [ANGLE_BITS-1:0]       angle,
	output logic                             done,
	output logic signed [TRIG_BITS-1:0]      value
);

	localparam int QB = ANGLE_BITS - 2;
	localparam int UW = Q_BITS + 1;
	localparam logic [3:0] LAST_STEP = 4'd7;
	localparam logic [UW-1:0] ONE_U = UW'(1) << Q_BITS;
	localparam logic [63:0] HALF_Q = 64'd1 << (Q_BITS - 1);
	localparam logic [TRIG_BITS-1:0] ONE_T = TRIG_BITS'(1) << Q_BITS;

	logic [3:0]           step_q;
	logic                 run_q;
	logic                 done_q;
	logic [UW-1:0]        u_q;
	logic [UW-1:0]        u2_q;
	logic [TRIG_BITS-1:0] p_q;
	logic                 neg_q;
	logic signed [TRIG_BITS-1:0] value_q;

	logic [1:0]           quad;
	logic [UW-1:0]        u_raw;
	logic [UW-1:0]        u_ld;
	logic [TRIG_BITS-1:0] op_a;
	logic [TRIG_BITS-1:0] op_b;
	logic [63:0]          rnd;
	logic [TRIG_BITS-1:0] pf;

	assign quad  = angle[ANGLE_BITS-1:ANGLE_BITS-2];
	assign u_raw = UW'({angle[QB-1:0], {(Q_BITS-QB){1'b0}}});
	assign u_ld  = quad[0] ? (ONE_U - u_raw) : u_raw;

	always_comb begin
		case (step_q)
			4'd0: begin
				op_a = TRIG_BITS'(u_q);
				op_b = TRIG_BITS'(u_q);
			end
			LAST_STEP: begin
				op_a = p_q;
				op_b = TRIG_BITS'(u_q);
			end
			default: begin
				op_a = p_q;
				op_b = TRIG_BITS'(u2_q);
			end
		endcase
		rnd = ((64'(op_a) * 64'(op_b)) + HALF_Q) >> Q_BITS;
		pf  = (rnd > 64'(ONE_T)) ? ONE_T : rnd[TRIG_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (load) begin
			step_q <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == LAST_STEP) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			u_q   <= u_ld;
			neg_q <= quad[1];
		end else if (run_q) begin
			case (step_q)
				4'd0: begin
					u2_q <= rnd[UW-1:0];
					p_q  <= SIN_COEF[6];
				end
				LAST_STEP: begin
					value_q <= neg_q ? -$signed(pf) : $signed(pf);
				end
				default: begin
					p_q <= SIN_COEF[3'(4'd6 - step_q)] - rnd[TRIG_BITS-1:0];
				end
			endcase
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

`default_nettype wire

@@ hw/rtl/aabbrst_front.sv @@
// Front end: accepts a transaction, runs six sine lanes for the three angles
// and hands the classified job to the queue. Depends on aabbrst_pkg, aabbrst_sine.
`default_nettype none

module aabbrst_front
	import aabbrst_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	input  wire logic  q_full,
	output logic       busy,
	output logic       push,
	output job_t       job
);

	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	logic                  pend_q;
	logic [2:0][COORD_BITS-1:0] gain_q;
	logic [2:0][COORD_BITS-1:0] shift_q;
	logic [ANGLE_BITS-1:0] turn [3];
	logic [5:0]            lane_done;
	logic signed [TRIG_BITS-1:0] sn_val [3];
	logic signed [TRIG_BITS-1:0] cs_val [3];
	logic                  accept;

	assign turn[0] = item.turn_x;
	assign turn[1] = item.turn_y;
	assign turn[2] = item.turn_z;

	for (genvar k = 0; k < 3; k++) begin : g_axis
		aabbrst_sine u_sin (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (accept),
			.angle  (turn[k]),
			.done   (lane_done[2*k]),
			.value  (sn_val[k])
		);
		aabbrst_sine u_cos (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (accept),
			.angle  (turn[k] + QUARTER),
			.done   (lane_done[2*k+1]),
			.value  (cs_val[k])
		);
		assign job.sn[k] = sn_val[k];
		assign job.cs[k] = cs_val[k];
	end

	assign push   = pend_q && (&lane_done) && !q_full;
	assign busy   = pend_q && !push;
	assign accept = start && !busy;
	assign job.gain  = gain_q;
	assign job.shift = shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (push) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gain_q  <= {item.gain_z, item.gain_y, item.gain_x};
			shift_q <= {item.shift_z, item.shift_y, item.shift_x};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/aabbrst_queue.sv @@
// Short job queue between front and back end.
// Depends on aabbrst_pkg.
`default_nettype none

module aabbrst_queue
	import aabbrst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_data,
	input  wire logic pop,
	output logic      full,
	output logic      nonempty,
	output job_t      rd_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/aabbrst_back.sv @@
// Back end: issues eight corners per job through a shared rotation pipeline,
// tracks min and max, then scales, shifts and saturates. Depends on aabbrst_pkg.
`default_nettype none

module aabbrst_back
	import aabbrst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire box_t box,
	input  wire logic q_valid,
	input  wire job_t q_data,
	output logic      pop,
	output logic      done,
	output res_t      result
);

	localparam int MW_R = ROT_BITS + TRIG_BITS;
	localparam int MW_P = ROT_BITS + COORD_BITS;
	localparam int PW   = MW_P - FRAC_BITS + 1;
	localparam logic [CORNER_BITS-1:0] LAST_CORNER = CORNER_BITS'(CORNERS - 1);
	localparam logic [MW_R-1:0] ROUND_R = MW_R'(1) << (Q_BITS - 1);
	localparam logic [MW_P-1:0] ROUND_P = MW_P'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW:0] TOP_V = (PW+1)'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [PW:0] BOT_V = -TOP_V - (PW+1)'(1);

	typedef struct packed {
		logic                       first;
		logic                       last;
		logic [2:0][ROT_BITS-1:0]   p;
		job_t                       job;
	} crn_t;

	typedef struct packed {
		logic                       first;
		logic                       last;
		logic [ROT_BITS-1:0]        keep;
		logic [3:0][MW_R-1:0]       mag;
		logic [3:0]                 neg;
		job_t                       job;
	} prd_t;

	function automatic logic [MW_R-1:0] rot_mag(logic signed [ROT_BITS-1:0] a,
			logic signed [TRIG_BITS-1:0] c);
		logic [ROT_BITS-1:0]  ma;
		logic [TRIG_BITS-1:0] mc;
		ma = a[ROT_BITS-1] ? ROT_BITS'(-a) : ROT_BITS'(a);
		mc = c[TRIG_BITS-1] ? TRIG_BITS'(-c) : TRIG_BITS'(c);
		return MW_R'(ma) * MW_R'(mc);
	endfunction

	function automatic logic signed [ROT_BITS-1:0] rot_rnd(logic [MW_R-1:0] mag, logic neg);
		logic [MW_R-1:0]     t;
		logic [ROT_BITS-1:0] r;
		t = (mag + ROUND_R) >> Q_BITS;
		r = t[ROT_BITS-1:0];
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic [MW_P-1:0] pl_mag(logic signed [ROT_BITS-1:0] a,
			logic signed [COORD_BITS-1:0] g);
		logic [ROT_BITS-1:0]   ma;
		logic [COORD_BITS-1:0] mg;
		ma = a[ROT_BITS-1] ? ROT_BITS'(-a) : ROT_BITS'(a);
		mg = g[COORD_BITS-1] ? COORD_BITS'(-g) : COORD_BITS'(g);
		return MW_P'(ma) * MW_P'(mg);
	endfunction

	// Corner issue.
	logic                   act_q;
	logic [CORNER_BITS-1:0] cnt_q;
	job_t                   cur_q;
	crn_t                   crn_in;

	assign pop = q_valid && (!act_q || cnt_q == LAST_CORNER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (pop) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (act_q) begin
			act_q <= (cnt_q != LAST_CORNER);
			cnt_q <= cnt_q + CORNER_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

	always_comb begin
		crn_in.first = (cnt_q == '0);
		crn_in.last  = (cnt_q == LAST_CORNER);
		crn_in.job   = cur_q;
		for (int j = 0; j < 3; j++) begin
			crn_in.p[j] = cnt_q[2-j] ? ROT_BITS'($signed(box.hi[j]))
				: ROT_BITS'($signed(box.lo[j]));
		end
	end

	// Rotation pipeline: per axis one product stage and one sum stage.
	crn_t crn_s [4];
	logic cvld_s [4];
	prd_t prd_s [3];
	logic pvld_s [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_s[0] <= 1'b0;
		end else begin
			cvld_s[0] <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		crn_s[0] <= crn_in;
	end

	for (genvar k = 0; k < 3; k++) begin : g_rot
		localparam int IA = (k + 1) % 3;
		localparam int IB = (k + 2) % 3;
		logic signed [ROT_BITS-1:0]  a;
		logic signed [ROT_BITS-1:0]  b;
		logic signed [TRIG_BITS-1:0] s;
		logic signed [TRIG_BITS-1:0] c;
		prd_t                        prd_nx;
		crn_t                        crn_nx;

		always_comb begin
			a = $signed(crn_s[k].p[IA]);
			b = $signed(crn_s[k].p[IB]);
			s = $signed(crn_s[k].job.sn[k]);
			c = $signed(crn_s[k].job.cs[k]);
			prd_nx.first  = crn_s[k].first;
			prd_nx.last   = crn_s[k].last;
			prd_nx.keep   = crn_s[k].p[k];
			prd_nx.job    = crn_s[k].job;
			prd_nx.mag[0] = rot_mag(a, c);
			prd_nx.neg[0] = a[ROT_BITS-1] ^ c[TRIG_BITS-1];
			prd_nx.mag[1] = rot_mag(b, s);
			prd_nx.neg[1] = b[ROT_BITS-1] ^ s[TRIG_BITS-1];
			prd_nx.mag[2] = rot_mag(a, s);
			prd_nx.neg[2] = a[ROT_BITS-1] ^ s[TRIG_BITS-1];
			prd_nx.mag[3] = rot_mag(b, c);
			prd_nx.neg[3] = b[ROT_BITS-1] ^ c[TRIG_BITS-1];
		end

		always_comb begin
			crn_nx.first = prd_s[k].first;
			crn_nx.last  = prd_s[k].last;
			crn_nx.job   = prd_s[k].job;
			crn_nx.p[k]  = prd_s[k].keep;
			crn_nx.p[IA] = rot_rnd(prd_s[k].mag[0], prd_s[k].neg[0])
				- rot_rnd(prd_s[k].mag[1], prd_s[k].neg[1]);
			crn_nx.p[IB] = rot_rnd(prd_s[k].mag[2], prd_s[k].neg[2])
				+ rot_rnd(prd_s[k].mag[3], prd_s[k].neg[3]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pvld_s[k]   <= 1'b0;
				cvld_s[k+1] <= 1'b0;
			end else begin
				pvld_s[k]   <= cvld_s[k];
				cvld_s[k+1] <= pvld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			prd_s[k]   <= prd_nx;
			crn_s[k+1] <= crn_nx;
		end
	end

	// Min and max over the eight rotated corners.
	logic signed [ROT_BITS-1:0] lo_q [3];
	logic signed [ROT_BITS-1:0] hi_q [3];
	logic signed [ROT_BITS-1:0] nlo [3];
	logic signed [ROT_BITS-1:0] nhi [3];
	logic signed [ROT_BITS-1:0] v;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			v = $signed(crn_s[3].p[j]);
			nlo[j] = (crn_s[3].first || v < lo_q[j]) ? v : lo_q[j];
			nhi[j] = (crn_s[3].first || v > hi_q[j]) ? v : hi_q[j];
		end
	end

	logic                       fvld_s8;
	logic signed [ROT_BITS-1:0] pt_s8 [6];
	job_t                       job_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_s8 <= 1'b0;
		end else begin
			fvld_s8 <= cvld_s[3] && crn_s[3].last;
		end
	end

	always_ff @(posedge clk) begin
		if (cvld_s[3]) begin
			for (int j = 0; j < 3; j++) begin
				lo_q[j]      <= nlo[j];
				hi_q[j]      <= nhi[j];
				pt_s8[j]     <= nlo[j];
				pt_s8[j + 3] <= nhi[j];
			end
			job_s8 <= crn_s[3].job;
		end
	end

	// Scale: one product per coordinate.
	logic              vld_s9;
	logic [MW_P-1:0]   mag_s9 [6];
	logic              neg_s9 [6];
	logic [2:0][COORD_BITS-1:0] shift_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= fvld_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int m = 0; m < 6; m++) begin
			mag_s9[m] <= pl_mag(pt_s8[m], $signed(job_s8.gain[m % 3]));
			neg_s9[m] <= pt_s8[m][ROT_BITS-1] ^ job_s8.gain[m % 3][COORD_BITS-1];
		end
		shift_s9 <= job_s8.shift;
	end

	// Round, shift and saturate.
	logic [COORD_BITS-1:0] out_v [6];
	logic                  clip_v;
	logic [MW_P-1:0]       t_p;
	logic [PW-1:0]         r_p;
	logic signed [PW:0]    sum_p;

	always_comb begin
		clip_v = 1'b0;
		for (int m = 0; m < 6; m++) begin
			t_p   = (mag_s9[m] + ROUND_P) >> FRAC_BITS;
			r_p   = t_p[PW-1:0];
			sum_p = (neg_s9[m] ? -(PW+1)'($signed(r_p)) : (PW+1)'($signed(r_p)))
				+ (PW+1)'($signed(shift_s9[m % 3]));
			if (sum_p > TOP_V) begin
				out_v[m] = TOP_V[COORD_BITS-1:0];
				clip_v   = 1'b1;
			end else if (sum_p < BOT_V) begin
				out_v[m] = BOT_V[COORD_BITS-1:0];
				clip_v   = 1'b1;
			end else begin
				out_v[m] = sum_p[COORD_BITS-1:0];
			end
		end
	end

	logic done_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s9) begin
			res_q.box_low_x  <= out_v[0];
			res_q.box_low_y  <= out_v[1];
			res_q.box_low_z  <= out_v[2];
			res_q.box_high_x <= out_v[3];
			res_q.box_high_y <= out_v[4];
			res_q.box_high_z <= out_v[5];
			res_q.clipped    <= clip_v;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/aabb_rotate_scale_translate.sv @@
// Top level of the transformed bounding-box block: configuration registers,
// front end, job queue and back end. Depends on aabbrst_pkg and all aabbrst_* modules.
//
// Usage. The local box (low and high corner) is written through the plain
// write port: cfg_we with cfg_addr 0..5 selects low x/y/z and high x/y/z,
// cfg_data carries the value; other addresses are ignored. Write it only
// while no transaction is in flight.
// A transaction is accepted at a rising edge with start high and busy low.
// Each one carries shift, gain and three binary angles, and yields exactly
// one result: done is high for one cycle with result valid in that cycle.
// The receiver cannot hold results off, and none is needed: results leave
// no faster than the back end issues the eight corners of a box. A job
// passes the sine lanes, the queue, corner issue, the rotation pipeline,
// min and max, scale and the result register. The six sine lanes of the
// front end set the pace of transactions, each evaluating its polynomial
// with one product per cycle. The back end rotates one corner per cycle in
// a shared rotate pipeline, eight corners per box, and a two-entry queue
// lets the front take the next transaction while the back is still working.
// Reset clears the local box to zero, empties the queue and drops all work
// in flight; no result appears until a new transaction is accepted.
`default_nettype none

module aabb_rotate_scale_translate
	import aabbrst_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [COORD_BITS-1:0]    cfg_data,
	input  wire logic                     start,
	input  wire item_t                    item,
	output logic                          busy,
	output logic                          done,
	output res_t                          result
);

	box_t box_q;
	job_t front_job;
	job_t head_job;
	logic push;
	logic pop;
	logic q_full;
	logic q_nonempty;

	// The local box: written at any time by the port, read by the corner
	// issue logic of the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_LOW_X:  box_q.lo[0] <= cfg_data;
				REG_LOW_Y:  box_q.lo[1] <= cfg_data;
				REG_LOW_Z:  box_q.lo[2] <= cfg_data;
				REG_HIGH_X: box_q.hi[0] <= cfg_data;
				REG_HIGH_Y: box_q.hi[1] <= cfg_data;
				REG_HIGH_Z: box_q.hi[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: takes the transaction and works out sines and cosines.
	aabbrst_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.job    (front_job)
	);

	// Queue decouples the two ends so each can stall on its own.
	aabbrst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (front_job),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.rd_data  (head_job)
	);

	// Back end: rotation, min and max, scale, shift and saturation.
	aabbrst_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.box     (box_q),
		.q_valid (q_nonempty),
		.q_data  (head_job),
		.pop     (pop),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

@@ hw/rtl/aabbrst_checker.sv @@
// Port-level checker for the transformed bounding-box block and its bind.
// Depends on aabbrst_pkg and aabb_rotate_scale_translate.
`default_nettype none

module aabbrst_checker
	import aabbrst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire res_t result
);

	localparam logic signed [COORD_BITS-1:0] MAX_C = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] MIN_C = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic [3:0] open_q;
	logic       accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + {3'd0, accept} - {3'd0, done};
		end
	end

	// A result never appears without an accepted transaction behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> open_q != '0)
		else $error("result without an open transaction");

	// The front end holds off the next transaction after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accept");

	// Results from successive boxes never arrive back to back.
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	// A clipped result has at least one coordinate at a range limit.
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.clipped) |->
			(result.box_low_x == MAX_C || result.box_low_x == MIN_C ||
			 result.box_low_y == MAX_C || result.box_low_y == MIN_C ||
			 result.box_low_z == MAX_C || result.box_low_z == MIN_C ||
			 result.box_high_x == MAX_C || result.box_high_x == MIN_C ||
			 result.box_high_y == MAX_C || result.box_high_y == MIN_C ||
			 result.box_high_z == MAX_C || result.box_high_z == MIN_C))
		else $error("clipped flag without a saturated coordinate");

endmodule

bind aabb_rotate_scale_translate aabbrst_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
